### rtl/weighted_union_find_top_macros.svh
// ----------------------------------------------------------------------------
// weighted_union_find_top_macros.svh
// Assertion macros used by the union-find datapath file.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_UNION_FIND_TOP_MACROS_SVH
`define WEIGHTED_UNION_FIND_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, masked while reset is held
`define WUF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds through reset
`define WUF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WUF_ASSERT(lbl, prop, msg)
`define WUF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/wuf_pkg.sv
// ----------------------------------------------------------------------------
// wuf_pkg
// Types, constants and the control store of the union-find engine.
// ----------------------------------------------------------------------------
package wuf_pkg;

  // vertex store geometry
  localparam int MAX_V  = 1024;
  localparam int VIDX_W = $clog2(MAX_V);
  localparam int CNT_W  = $clog2(MAX_V + 1);
  localparam int CFG_W  = 11;

  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // item kinds
  localparam logic KIND_UNION = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // step counter
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = STEP_W'(0);
  localparam step_t STEP_CHECK  = STEP_W'(1);
  localparam step_t STEP_WALK_P = STEP_W'(2);
  localparam step_t STEP_WALK_Q = STEP_W'(3);
  localparam step_t STEP_DECIDE = STEP_W'(4);
  localparam step_t STEP_SIZE_P = STEP_W'(5);
  localparam step_t STEP_SIZE_Q = STEP_W'(6);
  localparam step_t STEP_LINK   = STEP_W'(7);
  localparam step_t STEP_EMIT   = STEP_W'(8);
  localparam step_t STEP_LAST   = STEP_EMIT;

  // control word fields
  typedef enum logic [1:0] {CUR_HOLD, CUR_LOAD, CUR_WALK_P, CUR_WALK_Q} cur_op_t;
  typedef enum logic {SZA_RP, SZA_RQ} sza_t;
  typedef enum logic [1:0] {SZC_NONE, SZC_P, SZC_Q} szc_t;
  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NO_ACCEPT, C_ERR, C_NOT_ROOT, C_NO_MERGE, C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic    ready;
    cur_op_t cur_op;
    sza_t    sza;
    szc_t    sz_cap;
    logic    link;
    logic    emit;
    cond_t   cond;
    step_t   target;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic accept;
    logic err;
    logic not_root;
    logic no_merge;
  } stat_t;

  // one result beat
  typedef struct packed {
    vidx_t root_p;
    vidx_t root_q;
    logic  same_set;
    logic  merged;
    cnt_t  set_count;
    logic  index_error;
  } res_t;

  localparam ctrl_t CTRL_NOP = '{
    ready: 1'b0, cur_op: CUR_HOLD, sza: SZA_RP, sz_cap: SZC_NONE,
    link: 1'b0, emit: 1'b0, cond: C_NEVER, target: STEP_IDLE
  };

  // control store: one word per step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (s)
      STEP_IDLE: begin
        w.ready  = 1'b1;
        w.cur_op = CUR_LOAD;
        w.cond   = C_NO_ACCEPT;
        w.target = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.cond   = C_ERR;
        w.target = STEP_EMIT;
      end
      STEP_WALK_P: begin
        w.cur_op = CUR_WALK_P;
        w.cond   = C_NOT_ROOT;
        w.target = STEP_WALK_P;
      end
      STEP_WALK_Q: begin
        w.cur_op = CUR_WALK_Q;
        w.cond   = C_NOT_ROOT;
        w.target = STEP_WALK_Q;
      end
      STEP_DECIDE: begin
        w.sza    = SZA_RP;
        w.cond   = C_NO_MERGE;
        w.target = STEP_EMIT;
      end
      STEP_SIZE_P: begin
        w.sza    = SZA_RQ;
        w.sz_cap = SZC_P;
      end
      STEP_SIZE_Q: begin
        w.sz_cap = SZC_Q;
      end
      STEP_LINK: begin
        w.link = 1'b1;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/wuf_in_if.sv
// ----------------------------------------------------------------------------
// wuf_in_if
// Request channel: item kind and two vertex indices.
// ----------------------------------------------------------------------------
interface wuf_in_if;
  logic             valid;
  logic             ready;
  logic             kind;
  wuf_pkg::vidx_t   vertex_p;
  wuf_pkg::vidx_t   vertex_q;

  modport source (output valid, kind, vertex_p, vertex_q, input ready);
  modport sink   (input valid, kind, vertex_p, vertex_q, output ready);
endinterface

### rtl/wuf_out_if.sv
// ----------------------------------------------------------------------------
// wuf_out_if
// Result channel: both roots, flags and the current set count.
// ----------------------------------------------------------------------------
interface wuf_out_if;
  logic             valid;
  logic             ready;
  wuf_pkg::vidx_t   root_p;
  wuf_pkg::vidx_t   root_q;
  logic             same_set;
  logic             merged;
  wuf_pkg::cnt_t    set_count;
  logic             index_error;

  modport source (output valid, root_p, root_q, same_set, merged, set_count,
                  index_error, input ready);
  modport sink   (input valid, root_p, root_q, same_set, merged, set_count,
                  index_error, output ready);
endinterface

### rtl/weighted_union_find_top.sv
// ----------------------------------------------------------------------------
// weighted_union_find_top
// Weighted quick-union engine: union and connectivity query over up to
// 1024 vertices, one result beat per request beat.
// ----------------------------------------------------------------------------
// Use: a request beat on in_ch carries kind (union or query) and two vertex
// indices; each request gives exactly one result beat on out_ch with both
// roots, same-set and merged flags, the set count and an index error flag.
// cfg_we/cfg_wdata write the vertex count (saturated at 1024), which resets
// all sets; write it only while the engine is idle.
// From request to result beat: an index error goes from the check step
// straight to the final step; a query or a union within one set walks from
// p to its root and then from q to its root; a merging union then reads
// both sizes and links. The engine passes through the idle step before the
// next request. The walks follow one parent link per cycle through the
// single read port of the parent store; tree depth stays at most log2 of
// the vertex count. One item is in work at a time.
// Reset and every count write start a sweep that rewrites both stores;
// in_ch.ready stays low through it.
// The result sits in an output register: a stalled receiver holds it while
// the next request is already accepted and walked; that item waits in its
// final step until the register frees.
// ----------------------------------------------------------------------------
module weighted_union_find_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [wuf_pkg::CFG_W-1:0] cfg_wdata,
  wuf_in_if.sink                    in_ch,
  wuf_out_if.source                 out_ch
);
  import wuf_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  res_t  res;
  res_t  res_r;
  logic  out_valid_r;
  logic  out_busy;

  assign out_busy = out_valid_r && !out_ch.ready;

  wuf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  wuf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_kind     (in_ch.kind),
    .in_vertex_p (in_ch.vertex_p),
    .in_vertex_q (in_ch.vertex_q),
    .ctrl        (ctrl),
    .stat        (stat),
    .res         (res)
  );

  // output register: loaded in the final step when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && !out_busy) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.root_p      = res_r.root_p;
  assign out_ch.root_q      = res_r.root_q;
  assign out_ch.same_set    = res_r.same_set;
  assign out_ch.merged      = res_r.merged;
  assign out_ch.set_count   = res_r.set_count;
  assign out_ch.index_error = res_r.index_error;

endmodule

### rtl/wuf_ram.sv
// ----------------------------------------------------------------------------
// wuf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/wuf_seq.sv
// ----------------------------------------------------------------------------
// wuf_seq
// Step counter and control store fetch with conditional jumps.
// ----------------------------------------------------------------------------
module wuf_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  wuf_pkg::stat_t  stat,
  input  logic            out_busy,
  output wuf_pkg::ctrl_t  ctrl
);
  import wuf_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  logic  taken;

  // fetch the control word of the current step
  assign ctrl = ucode(pc_r);

  // jump condition
  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_ACCEPT: taken = !stat.accept;
      C_ERR:       taken = stat.err;
      C_NOT_ROOT:  taken = stat.not_root;
      C_NO_MERGE:  taken = stat.no_merge;
      C_OUT_BUSY:  taken = out_busy;
      default:     taken = 1'b1;
    endcase
  end

  // next step: jump, or fall through with wrap after the last step
  always_comb begin
    priority if (taken) begin
      pc_nxt = ctrl.target;
    end else if (pc_r >= STEP_LAST) begin
      pc_nxt = STEP_IDLE;
    end else begin
      pc_nxt = pc_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### rtl/wuf_dp.sv
// ----------------------------------------------------------------------------
// wuf_dp
// Datapath: parent and size stores, root walk registers, set count and the
// clearing sweep after reset or a vertex count write.
// ----------------------------------------------------------------------------
`include "weighted_union_find_top_macros.svh"

module wuf_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [wuf_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  wuf_pkg::vidx_t             in_vertex_p,
  input  wuf_pkg::vidx_t             in_vertex_q,
  input  wuf_pkg::ctrl_t             ctrl,
  output wuf_pkg::stat_t             stat,
  output wuf_pkg::res_t              res
);
  import wuf_pkg::*;

  // control state
  logic  clearing_r;
  vidx_t clr_idx_r;
  cnt_t  vc_r;
  cnt_t  comp_r;
  cnt_t  vc_sat;

  // item registers
  logic  kind_r;
  logic  err_r;
  logic  merged_r;
  vidx_t q_r;
  vidx_t cur_r;
  vidx_t cur_nxt;
  vidx_t rp_r;
  vidx_t rq_r;
  cnt_t  sz_p_r;
  cnt_t  sz_q_r;

  // store ports
  logic  par_we;
  vidx_t par_waddr;
  vidx_t par_wdata;
  vidx_t par_raddr;
  vidx_t par_rdata;
  logic  sz_we;
  vidx_t sz_waddr;
  cnt_t  sz_wdata;
  vidx_t sz_raddr;
  cnt_t  sz_rdata;

  logic  accept;
  logic  root_hit;
  logic  p_smaller;
  logic  in_err;
  cnt_t  sz_sum;

  assign in_ready = ctrl.ready && !clearing_r;
  assign accept   = in_valid && in_ready;
  assign root_hit = (par_rdata == cur_r);

  // range check against the live vertex count
  assign in_err = (CNT_W'(in_vertex_p) >= vc_r) || (CNT_W'(in_vertex_q) >= vc_r);

  // saturate a written count at the store depth
  assign vc_sat = (CNT_W'(cfg_wdata) > CNT_W'(MAX_V)) ? CNT_W'(MAX_V)
                                                      : CNT_W'(cfg_wdata);

  // walk pointer; the parent read address always follows it, so in the next
  // cycle the registered read data lines up with cur_r
  always_comb begin
    unique case (ctrl.cur_op)
      CUR_HOLD:   cur_nxt = cur_r;
      CUR_LOAD:   cur_nxt = accept ? in_vertex_p : cur_r;
      CUR_WALK_P: cur_nxt = root_hit ? q_r : par_rdata;
      CUR_WALK_Q: cur_nxt = root_hit ? cur_r : par_rdata;
    endcase
  end

  assign par_raddr = cur_nxt;
  assign sz_raddr  = (ctrl.sza == SZA_RQ) ? rq_r : rp_r;

  // smaller tree goes under the larger; ties put q's root under p's
  assign p_smaller = (sz_p_r < sz_q_r);
  assign sz_sum    = sz_p_r + sz_q_r;

  // store write ports: sweep or link
  always_comb begin
    if (clearing_r) begin
      par_we    = 1'b1;
      par_waddr = clr_idx_r;
      par_wdata = clr_idx_r;
      sz_we     = 1'b1;
      sz_waddr  = clr_idx_r;
      sz_wdata  = CNT_W'(1);
    end else begin
      par_we    = ctrl.link;
      par_waddr = p_smaller ? rp_r : rq_r;
      par_wdata = p_smaller ? rq_r : rp_r;
      sz_we     = ctrl.link;
      sz_waddr  = p_smaller ? rq_r : rp_r;
      sz_wdata  = sz_sum;
    end
  end

  wuf_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_V)) u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  wuf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_V)) u_size (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  // control state: count, set count and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      vc_r       <= CNT_W'(MAX_V);
      comp_r     <= CNT_W'(MAX_V);
    end else if (cfg_we) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
      vc_r       <= vc_sat;
      comp_r     <= vc_sat;
    end else begin
      if (clearing_r) begin
        clr_idx_r <= clr_idx_r + VIDX_W'(1);
        if (clr_idx_r == VIDX_W'(MAX_V - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (ctrl.link && (comp_r != '0)) begin
        comp_r <= comp_r - CNT_W'(1);
      end
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if ((ctrl.cur_op == CUR_LOAD) && accept) begin
      kind_r   <= in_kind;
      q_r      <= in_vertex_q;
      err_r    <= in_err;
      merged_r <= 1'b0;
    end
    if ((ctrl.cur_op == CUR_WALK_P) && root_hit) begin
      rp_r <= cur_r;
    end
    if ((ctrl.cur_op == CUR_WALK_Q) && root_hit) begin
      rq_r <= cur_r;
    end
    if (ctrl.sz_cap == SZC_P) begin
      sz_p_r <= sz_rdata;
    end
    if (ctrl.sz_cap == SZC_Q) begin
      sz_q_r <= sz_rdata;
    end
    if (ctrl.link) begin
      merged_r <= 1'b1;
    end
  end

  // flags to the sequencer
  assign stat.accept   = accept;
  assign stat.err      = err_r;
  assign stat.not_root = !root_hit;
  assign stat.no_merge = (kind_r == KIND_QUERY) || (rp_r == rq_r);

  // result fields; an index error reports zero roots and flags
  assign res.root_p      = err_r ? '0 : rp_r;
  assign res.root_q      = err_r ? '0 : rq_r;
  assign res.same_set    = !err_r && (rp_r == rq_r);
  assign res.merged      = !err_r && merged_r;
  assign res.set_count   = comp_r;
  assign res.index_error = err_r;

  `WUF_ASSERT(a_comp_le_vc, comp_r <= vc_r, "set count above vertex count")
  `WUF_ASSERT(a_link_roots, ctrl.link |-> (rp_r != rq_r), "link of one root to itself")
  `WUF_ASSERT(a_link_sizes, ctrl.link |-> ((sz_p_r != '0) && (sz_q_r != '0)), "empty tree linked")
  `WUF_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> clearing_r, "no clearing sweep after reset")

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted quick-union engine.
// ----------------------------------------------------------------------------
// A short table of directed beats (reset state, index extremes, out-of-range
// indices, zero and saturated vertex counts) is followed by phases of random
// traffic. Each phase writes a new vertex count. Some phases first build
// balanced trees pair by pair so that the root walks go deep, then mix random
// unions and queries. A local disjoint-set model predicts unlisted results.
// The receiver compares each beat field by field in arrival order. Idling on
// both channels, one long receiver hold-off and a full drain are included.
// ----------------------------------------------------------------------------
module tb_top;
  import wuf_pkg::*;

  localparam int STALL_LIMIT = 10000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int N_ROWS      = 28;
  localparam int N_PHASES    = 8;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  wuf_in_if  in_ch();
  wuf_out_if out_ch();

  weighted_union_find_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Disjoint-set model
  // --------------------------------------------------------------------------
  vidx_t parent_of [MAX_V];
  cnt_t  tree_sz   [MAX_V];
  cnt_t  sets_left;
  cnt_t  n_vertices;

  res_t  pending_results [$];
  int    results_owed;
  int    mismatches;

  // count write or reset: every vertex alone again, count saturates
  function automatic void load_vertex_count(logic [CFG_W-1:0] v);
    n_vertices = (v > MAX_V) ? cnt_t'(MAX_V) : cnt_t'(v);
    for (int i = 0; i < MAX_V; i++) begin
      parent_of[i] = vidx_t'(i);
      tree_sz[i]   = cnt_t'(1);
    end
    sets_left = n_vertices;
  endfunction

  function automatic vidx_t root_of(vidx_t v);
    int steps;
    steps = 0;
    while (parent_of[v] != v && steps < MAX_V) begin
      v = parent_of[v];
      steps++;
    end
    return v;
  endfunction

  // one request: roots before any merge, then weighted link
  function automatic res_t join_or_query(logic kind, vidx_t p, vidx_t q);
    res_t  r;
    vidx_t rp;
    vidx_t rq;
    r = '0;
    if (p >= n_vertices || q >= n_vertices) begin
      r.index_error = 1'b1;
    end else begin
      rp = root_of(p);
      rq = root_of(q);
      r.root_p   = rp;
      r.root_q   = rq;
      r.same_set = (rp == rq);
      if (kind == KIND_UNION && rp != rq) begin
        // smaller tree goes under; a tie puts q's root under p's
        if (tree_sz[rp] < tree_sz[rq]) begin
          parent_of[rp] = rq;
          tree_sz[rq]   = tree_sz[rq] + tree_sz[rp];
        end else begin
          parent_of[rq] = rp;
          tree_sz[rp]   = tree_sz[rp] + tree_sz[rq];
        end
        if (sets_left > 0) sets_left = sets_left - 1'b1;
        r.merged = 1'b1;
      end
    end
    r.set_count = sets_left;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    logic             is_cfg;
    logic [CFG_W-1:0] cfg_val;
    logic             kind;
    vidx_t            p;
    vidx_t            q;
    logic             known;
    res_t             want;
  } row_t;

  function automatic res_t res_lit(vidx_t rp, vidx_t rq, logic same, logic merged,
                                   cnt_t cnt, logic err);
    res_t r;
    r.root_p      = rp;
    r.root_q      = rq;
    r.same_set    = same;
    r.merged      = merged;
    r.set_count   = cnt;
    r.index_error = err;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CFG_W-1:0] v);
    return '{1'b1, v, KIND_QUERY, '0, '0, 1'b0, '0};
  endfunction

  function automatic row_t item_row(logic kind, vidx_t p, vidx_t q);
    return '{1'b0, '0, kind, p, q, 1'b0, '0};
  endfunction

  function automatic row_t known_row(logic kind, vidx_t p, vidx_t q, res_t want);
    return '{1'b0, '0, kind, p, q, 1'b1, want};
  endfunction

  row_t dir_rows [N_ROWS] = '{
    // fresh after reset, 1024 vertices
    known_row(KIND_QUERY, 10'd0,    10'd0,    res_lit(0, 0, 1, 0, 1024, 0)),
    known_row(KIND_QUERY, 10'd1023, 10'd1023, res_lit(1023, 1023, 1, 0, 1024, 0)),
    known_row(KIND_UNION, 10'd0,    10'd1023, res_lit(0, 1023, 0, 1, 1023, 0)),
    known_row(KIND_UNION, 10'd1023, 10'd0,    res_lit(0, 0, 1, 0, 1023, 0)),
    item_row (KIND_UNION, 10'd5,    10'd6),
    item_row (KIND_UNION, 10'd6,    10'd0),
    item_row (KIND_UNION, 10'd7,    10'd1023),
    item_row (KIND_QUERY, 10'd7,    10'd0),
    // four vertices: out-of-range indices
    cfg_row(11'd4),
    known_row(KIND_UNION, 10'd3,    10'd2,    res_lit(3, 2, 0, 1, 3, 0)),
    known_row(KIND_UNION, 10'd4,    10'd0,    res_lit(0, 0, 0, 0, 3, 1)),
    known_row(KIND_QUERY, 10'd0,    10'd1023, res_lit(0, 0, 0, 0, 3, 1)),
    known_row(KIND_QUERY, 10'd1023, 10'd1023, res_lit(0, 0, 0, 0, 3, 1)),
    item_row (KIND_UNION, 10'd1,    10'd0),
    item_row (KIND_UNION, 10'd0,    10'd3),
    item_row (KIND_QUERY, 10'd2,    10'd0),
    // zero vertices: everything is out of range
    cfg_row(11'd0),
    known_row(KIND_QUERY, 10'd0,    10'd0,    res_lit(0, 0, 0, 0, 0, 1)),
    known_row(KIND_UNION, 10'd1023, 10'd0,    res_lit(0, 0, 0, 0, 0, 1)),
    // single vertex
    cfg_row(11'd1),
    known_row(KIND_UNION, 10'd0,    10'd0,    res_lit(0, 0, 1, 0, 1, 0)),
    known_row(KIND_QUERY, 10'd0,    10'd1,    res_lit(0, 0, 0, 0, 1, 1)),
    known_row(KIND_QUERY, 10'd1,    10'd0,    res_lit(0, 0, 0, 0, 1, 1)),
    // top of the count field saturates to 1024
    cfg_row(11'd2047),
    known_row(KIND_QUERY, 10'd1023, 10'd0,    res_lit(1023, 0, 0, 0, 1024, 0)),
    item_row (KIND_UNION, 10'd512,  10'd511),
    item_row (KIND_UNION, 10'd1023, 10'd511),
    item_row (KIND_QUERY, 10'd511,  10'd512)
  };

  // random phases: count written, balanced build span, random beats, index span
  typedef struct {
    logic [CFG_W-1:0] count;
    int               build_span;
    int               rand_items;
    int               rand_span;
  } phase_t;

  phase_t phases [N_PHASES] = '{
    '{11'd1024, 128, 100, 1024},
    '{11'd64,   64,  150, 64},
    '{11'd1000, 0,   250, 1000},
    '{11'd16,   0,   150, 16},
    '{11'd1025, 256, 100, 256},
    '{11'd5,    0,   80,  5},
    '{11'd1,    0,   30,  1},
    '{11'd0,    0,   20,  0}
  };

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic hold_request;

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        tx_idle_pct = 31;
        rx_idle_pct <= 83;
      end
      1: begin
        tx_idle_pct = 83;
        rx_idle_pct <= 31;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
    endcase
  endtask

  // offer one beat, hold it until taken, then log what must come back
  task automatic send_item(logic kind, vidx_t p, vidx_t q, logic known, res_t want);
    int   gap;
    res_t predicted;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.vertex_p <= p;
    in_ch.vertex_q <= q;
    do @(posedge clk); while (!in_ch.ready);
    predicted = join_or_query(kind, p, q);
    pending_results.push_back(known ? want : predicted);
    results_owed++;
  endtask

  // stop offering and wait for every outstanding result beat
  task automatic drain_all();
    in_ch.valid <= 1'b0;
    wait (results_owed == 0);
    @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [CFG_W-1:0] v);
    drain_all();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    load_vertex_count(v);
  endtask

  // mostly inside the span, now and then anywhere in the field
  function automatic vidx_t pick_vertex(int span);
    if (span == 0 || $urandom_range(99) < 10) return vidx_t'($urandom_range(1023));
    return vidx_t'($urandom_range(span - 1));
  endfunction

  function automatic logic pick_kind();
    return ($urandom_range(99) < 60) ? KIND_UNION : KIND_QUERY;
  endfunction

  // pairwise merge of equal blocks: tree depth grows by one per level
  task automatic build_balanced(int span);
    vidx_t p;
    vidx_t q;
    vidx_t t;
    for (int step = 1; step < span; step = step * 2) begin
      for (int base = 0; base + step < span; base = base + 2 * step) begin
        if ($urandom_range(99) < 20)
          send_item(KIND_QUERY, pick_vertex(span), pick_vertex(span), 1'b0, '0);
        if ($urandom_range(99) < 5)
          send_item(pick_kind(), pick_vertex(0), pick_vertex(0), 1'b0, '0);
        p = vidx_t'(base + $urandom_range(step - 1));
        q = vidx_t'(base + step + $urandom_range(step - 1));
        if ($urandom_range(1)) begin
          t = p;
          p = q;
          q = t;
        end
        send_item(KIND_UNION, p, q, 1'b0, '0);
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_UNION;
    in_ch.vertex_p <= '0;
    in_ch.vertex_q <= '0;
    hold_request   <= 1'b0;
    results_owed   = 0;
    mismatches     = 0;
    load_vertex_count(11'd1024);
    set_idling(0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_vertex_count(dir_rows[i].cfg_val);
      else
        send_item(dir_rows[i].kind, dir_rows[i].p, dir_rows[i].q,
                  dir_rows[i].known, dir_rows[i].want);
    end

    // random phases
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_vertex_count(phases[ph].count);
      set_idling(ph % 3);
      if (phases[ph].build_span > 0) build_balanced(phases[ph].build_span);
      // long receiver hold-off while beats keep coming
      if (ph == 2) hold_request <= 1'b1;
      for (int i = 0; i < phases[ph].rand_items; i++) begin
        // once: let everything come home mid-phase
        if (ph == 3 && i == phases[ph].rand_items / 2) drain_all();
        send_item(pick_kind(), pick_vertex(phases[ph].rand_span),
                  pick_vertex(phases[ph].rand_span), 1'b0, '0);
      end
    end

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    int   hold_left;
    logic hold_done;
    res_t want;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_owed--;
          check_field("root_p",      CNT_W'(want.root_p),      CNT_W'(out_ch.root_p));
          check_field("root_q",      CNT_W'(want.root_q),      CNT_W'(out_ch.root_q));
          check_field("same_set",    CNT_W'(want.same_set),    CNT_W'(out_ch.same_set));
          check_field("merged",      CNT_W'(want.merged),      CNT_W'(out_ch.merged));
          check_field("set_count",   want.set_count,           out_ch.set_count);
          check_field("index_error", CNT_W'(want.index_error), CNT_W'(out_ch.index_error));
        end
      end
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog: too long without any beat on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

### weighted_union_find_top.f
+incdir+rtl
rtl/wuf_pkg.sv
rtl/wuf_in_if.sv
rtl/wuf_out_if.sv
rtl/wuf_ram.sv
rtl/wuf_seq.sv
rtl/wuf_dp.sv
rtl/weighted_union_find_top.sv
bench/tb_top.sv
